// ----- sv/stss_pkg.sv -----
// Shared constants, codes and interface types for the subarray target sum search.
package stss_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int ELEM_W    = 16;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int CNT_W     = IDX_W + 1;
    localparam int SUM_W     = 32;
    localparam int TARGET_W  = 31;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 10;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SUB
    } ctrl_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic sub;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic shrink;
        logic has_result;
        logic out_busy;
    } dp_status_t;

endpackage

// ----- sv/stss_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module stss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word and register one read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/stss_ctrl.sv -----
// Controller state machine: sequences accept, window shrink and result commit.
module stss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  stss_pkg::dp_status_t dp_status,
    output stss_pkg::dp_cmd_t    dp_cmd
);
    import stss_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Choose the next state and drive commands
    always_comb
    begin
        state_next    = state_reg;
        dp_cmd.accept = 1'b0;
        dp_cmd.sub    = 1'b0;
        dp_cmd.finish = 1'b0;
        in_stall      = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    dp_cmd.accept = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dp_status.shrink)
                begin
                    state_next = S_SUB;
                end
                else if (!(dp_status.has_result && dp_status.out_busy))
                begin
                    dp_cmd.finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SUB:
            begin
                dp_cmd.sub = 1'b1;
                state_next = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/stss_dp.sv -----
// Datapath: window store, running sum, indices, flags and the result register.
module stss_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [stss_pkg::TARGET_W-1:0]     target_sum,
    input  logic [stss_pkg::ELEM_W-1:0]       element_value,
    input  logic                              last_element,
    input  stss_pkg::dp_cmd_t                 dp_cmd,
    output stss_pkg::dp_status_t              dp_status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stss_pkg::STATUS_W-1:0]     status,
    output logic [stss_pkg::OUT_IDX_W-1:0]    first_index,
    output logic [stss_pkg::OUT_IDX_W-1:0]    last_index
);
    import stss_pkg::*;

    logic [SUM_W-1:0]     total_reg;
    logic [IDX_W-1:0]     start_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     k_reg;
    logic                 answer_reg;
    logic                 too_long_reg;
    logic                 proc_reg;
    logic                 last_reg;
    logic                 out_valid_reg;
    status_t              status_reg;
    logic [IDX_W-1:0]     first_reg;
    logic [IDX_W-1:0]     lastidx_reg;
    logic [ELEM_W-1:0]    rd_data;
    logic                 open_arr;
    logic                 full;
    logic                 wr_en;
    logic                 found;
    logic [SUM_W-1:0]     target_ext;

    assign target_ext = SUM_W'(target_sum);
    assign open_arr   = !answer_reg && !too_long_reg;
    assign full       = (count_reg == CNT_W'(MAX_LEN));
    assign wr_en      = dp_cmd.accept && open_arr && !full;
    assign found      = proc_reg && (total_reg == target_ext);

    // Status toward the controller
    assign dp_status.shrink     = proc_reg && (total_reg > target_ext) && (start_reg < k_reg);
    assign dp_status.has_result = found || (last_reg && !answer_reg);
    assign dp_status.out_busy   = out_valid_reg && out_stall;

    stss_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (element_value),
        .raddr (start_reg),
        .rdata (rd_data)
    );

    // Advance window and array state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            start_reg    <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            answer_reg   <= 1'b0;
            too_long_reg <= 1'b0;
            proc_reg     <= 1'b0;
            last_reg     <= 1'b0;
        end
        else if (dp_cmd.accept)
        begin
            last_reg <= last_element;
            proc_reg <= open_arr && !full;
            if (open_arr && full)
            begin
                too_long_reg <= 1'b1;
            end
            if (wr_en)
            begin
                total_reg <= total_reg + SUM_W'(element_value);
                k_reg     <= count_reg[IDX_W-1:0];
                count_reg <= count_reg + CNT_W'(1);
            end
        end
        else if (dp_cmd.sub)
        begin
            total_reg <= total_reg - SUM_W'(rd_data);
            start_reg <= start_reg + IDX_W'(1);
        end
        else if (dp_cmd.finish)
        begin
            proc_reg <= 1'b0;
            if (last_reg)
            begin
                // Clear sum, start, count and flags for the next array
                total_reg    <= '0;
                start_reg    <= '0;
                count_reg    <= '0;
                answer_reg   <= 1'b0;
                too_long_reg <= 1'b0;
                last_reg     <= 1'b0;
            end
            else if (found)
            begin
                answer_reg <= 1'b1;
            end
        end
    end

    // Hold the output beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dp_cmd.finish && dp_status.has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (dp_cmd.finish && dp_status.has_result)
        begin
            if (found)
            begin
                status_reg  <= ST_FOUND;
                first_reg   <= start_reg;
                lastidx_reg <= k_reg;
            end
            else
            begin
                status_reg  <= too_long_reg ? ST_TOO_LONG : ST_NOT_FOUND;
                first_reg   <= '0;
                lastidx_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign first_index = OUT_IDX_W'(first_reg);
    assign last_index  = OUT_IDX_W'(lastidx_reg);

endmodule

// ----- sv/subarray_target_sum_search.sv -----
// An element is taken in S_IDLE and checked in S_CHECK; each element dropped from the
// window adds a pass through S_SUB and back to S_CHECK, and an element is dropped at
// most once (one RAM read per drop). Input is stalled outside S_IDLE, so no new element
// is taken until the last is done. A result waits in an output register.
// Reset (rst_n, async, active low) clears controller, flags, sums and target, not the RAM.
module subarray_target_sum_search (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [stss_pkg::TARGET_W-1:0]     cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [stss_pkg::ELEM_W-1:0]       element_value,
    input  logic                              last_element,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [stss_pkg::STATUS_W-1:0]     status,
    output logic [stss_pkg::OUT_IDX_W-1:0]    first_index,
    output logic [stss_pkg::OUT_IDX_W-1:0]    last_index
);
    import stss_pkg::*;

    logic [TARGET_W-1:0] target_reg;
    dp_cmd_t             dp_cmd;
    dp_status_t          dp_status;

    // Hold the target register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (cfg_we)
        begin
            target_reg <= cfg_wdata;
        end
    end

    stss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    stss_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .target_sum    (target_reg),
        .element_value (element_value),
        .last_element  (last_element),
        .dp_cmd        (dp_cmd),
        .dp_status     (dp_status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .first_index   (first_index),
        .last_index    (last_index)
    );

endmodule

// ----- tb/sv/tb_subarray_target_sum_search.sv -----
// Self-checking testbench for the subarray target sum search: directed table, then random arrays.
module tb_subarray_target_sum_search;
    timeunit 1ns;
    timeprecision 1ps;

    import stss_pkg::*;

    // Drain margin: one element may drop a full window.
    localparam int DRAIN_CYCLES = 2 * MAX_LEN + 16;
    // Longest quiet stretch in a correct run is a drain margin plus a full shrink
    // plus the longest gap and stall bursts; allow several times that.
    localparam int STUCK_LIMIT  = 5 * (DRAIN_CYCLES + 2 * MAX_LEN + 32);
    localparam int DIR_N        = 22;
    localparam int PHASES       = 16;

    typedef struct packed {
        status_t                status;
        logic [OUT_IDX_W-1:0]   first_idx;
        logic [OUT_IDX_W-1:0]   last_idx;
    } match_t;

    typedef struct packed {
        logic                   set_goal;
        logic [TARGET_W-1:0]    goal;
        logic [ELEM_W-1:0]      value;
        logic                   fin;
        logic                   typed;
        logic                   has;
        match_t                 ans;
    } row_t;

    localparam match_t NO_MATCH = '{ST_FOUND, 10'd0, 10'd0};

    // DUT ports
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [TARGET_W-1:0]    cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [ELEM_W-1:0]      element_value = '0;
    logic                   last_element = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [OUT_IDX_W-1:0]   first_index;
    logic [OUT_IDX_W-1:0]   last_index;

    // Typed answer that travels with the current beat
    logic                   beat_typed = 1'b0;
    logic                   beat_has = 1'b0;
    match_t                 beat_ans = NO_MATCH;

    // Idling controls
    logic                   tx_idle = 1'b1;
    logic                   rx_idle = 1'b1;
    int unsigned            rx_left = 0;

    // Search state mirrored by the testbench
    logic [ELEM_W-1:0]      win_mem [MAX_LEN];
    longint unsigned        win_sum = 0;
    int unsigned            win_head = 0;
    int unsigned            taken = 0;
    bit                     matched = 1'b0;
    bit                     overflowed = 1'b0;
    logic [TARGET_W-1:0]    goal = '0;

    match_t                 pending_answers [$];
    logic [ELEM_W-1:0]      array_elems [$];
    int unsigned            mismatches = 0;
    int unsigned            quiet_cycles = 0;
    bit                     step_hit;
    match_t                 step_res;
    match_t                 oldest;
    bit                     any_beat;

    row_t directed_rows [DIR_N] = '{
        // target 0 straight after reset: a zero element matches, a nonzero one does not
        '{1'b0, 31'd0,          16'd0,     1'b1, 1'b1, 1'b1, '{ST_FOUND, 10'd0, 10'd0}},
        '{1'b0, 31'd0,          16'd1,     1'b1, 1'b1, 1'b1, '{ST_NOT_FOUND, 10'd0, 10'd0}},
        '{1'b0, 31'd0,          16'd3,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd0,     1'b1, 1'b0, 1'b0, NO_MATCH},
        // whole array matches on the last element
        '{1'b1, 31'd10,         16'd3,     1'b0, 1'b1, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd4,     1'b0, 1'b1, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd3,     1'b1, 1'b1, 1'b1, '{ST_FOUND, 10'd0, 10'd2}},
        // oversized first element that cannot be dropped alone
        '{1'b0, 31'd0,          16'd20,    1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd6,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd4,     1'b1, 1'b0, 1'b0, NO_MATCH},
        // largest element
        '{1'b1, 31'd65535,      16'hFFFF,  1'b1, 1'b1, 1'b1, '{ST_FOUND, 10'd0, 10'd0}},
        // largest target, never reached
        '{1'b1, 31'h7FFF_FFFF,  16'hFFFF,  1'b0, 1'b1, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'hFFFF,  1'b1, 1'b1, 1'b1, '{ST_NOT_FOUND, 10'd0, 10'd0}},
        // match on the first element, rest consumed silently
        '{1'b1, 31'd7,          16'd7,     1'b0, 1'b1, 1'b1, '{ST_FOUND, 10'd0, 10'd0}},
        '{1'b0, 31'd0,          16'd9,     1'b0, 1'b1, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd0,     1'b1, 1'b1, 1'b0, NO_MATCH},
        // window slides past the head before matching
        '{1'b1, 31'd5,          16'd9,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd2,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd3,     1'b1, 1'b0, 1'b0, NO_MATCH},
        // every element too big
        '{1'b0, 31'd0,          16'd6,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd6,     1'b0, 1'b0, 1'b0, NO_MATCH},
        '{1'b0, 31'd0,          16'd6,     1'b1, 1'b0, 1'b0, NO_MATCH}
    };

    subarray_target_sum_search i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .element_value (element_value),
        .last_element  (last_element),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .first_index   (first_index),
        .last_index    (last_index)
    );

    always #2ns clk = ~clk;

    // Advance the window search by one element and return the answer it causes
    function automatic void search_step(input logic [ELEM_W-1:0] v, input bit fin,
                                        output bit hit, output match_t res);
        int unsigned k;
        hit = 1'b0;
        res = NO_MATCH;
        if (!matched && !overflowed) begin
            if (taken >= MAX_LEN) begin
                overflowed = 1'b1;
            end
            else begin
                k = taken;
                win_mem[k] = v;
                win_sum += v;
                taken = k + 1;
                while (win_sum > goal && win_head < k) begin
                    win_sum -= win_mem[win_head];
                    win_head++;
                end
                if (win_sum == goal) begin
                    matched = 1'b1;
                    hit = 1'b1;
                    res = '{ST_FOUND, win_head[OUT_IDX_W-1:0], k[OUT_IDX_W-1:0]};
                end
            end
        end
        if (fin) begin
            if (!hit && !matched) begin
                hit = 1'b1;
                res = '{overflowed ? ST_TOO_LONG : ST_NOT_FOUND, 10'd0, 10'd0};
            end
            win_sum = 0;
            win_head = 0;
            taken = 0;
            matched = 1'b0;
            overflowed = 1'b0;
        end
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic logic [ELEM_W-1:0] noise_elem(input int unsigned emax);
        if ($urandom_range(0, 7) == 0)
            return ELEM_W'($urandom_range(0, 65535));
        return ELEM_W'($urandom_range(0, emax));
    endfunction

    // Build one array, optionally with a run that sums exactly to the target
    task automatic build_array(input longint unsigned tgt, input int unsigned emax,
                               input int unsigned len, input bit plant);
        int unsigned pre;
        longint unsigned rest;
        longint unsigned piece;
        array_elems.delete();
        pre = plant ? $urandom_range(0, len / 2) : len;
        repeat (pre) array_elems.push_back(noise_elem(emax));
        if (plant) begin
            rest = tgt;
            do begin
                piece = $urandom_range(1, emax);
                if (piece > rest)
                    piece = rest;
                array_elems.push_back(piece[ELEM_W-1:0]);
                rest -= piece;
            end while (rest != 0);
            while (array_elems.size() < len)
                array_elems.push_back(noise_elem(emax));
        end
    endtask

    // Present one beat, with an optional idle burst ahead of it, and wait for acceptance
    task automatic send_beat(input logic [ELEM_W-1:0] v, input bit fin, input bit typed,
                             input bit has, input match_t ans);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        last_element  <= fin;
        beat_typed    <= typed;
        beat_has      <= has;
        beat_ans      <= ans;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic send_array();
        foreach (array_elems[i])
            send_beat(array_elems[i], i == array_elems.size() - 1, 1'b0, 1'b0, NO_MATCH);
    endtask

    // Hold the sender until every answer is back and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_goal(input logic [TARGET_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Receiver stall bursts
    always @(posedge clk) begin
        if (rx_left != 0) begin
            out_stall <= 1'b1;
            rx_left   <= rx_left - 1;
        end
        else if (rx_idle && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            rx_left   <= $urandom_range(0, 15);
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    // Track config, predict on each accepted element, check each accepted result
    always @(posedge clk) begin
        any_beat = 1'b0;
        if (rst_n) begin
            if (cfg_we)
                goal = cfg_wdata;
            if (in_valid && !in_stall) begin
                any_beat = 1'b1;
                search_step(element_value, last_element, step_hit, step_res);
                if (beat_typed) begin
                    step_hit = beat_has;
                    step_res = beat_ans;
                end
                if (step_hit)
                    pending_answers.push_back(step_res);
            end
            if (out_valid && !out_stall) begin
                any_beat = 1'b1;
                if (pending_answers.size() == 0) begin
                    report($sformatf("unexpected result status=%0d first=%0d last=%0d",
                                     status, first_index, last_index));
                end
                else begin
                    oldest = pending_answers.pop_front();
                    if (status !== oldest.status)
                        report($sformatf("status %0d, expected %0d", status, oldest.status));
                    if (first_index !== oldest.first_idx)
                        report($sformatf("first_index %0d, expected %0d",
                                         first_index, oldest.first_idx));
                    if (last_index !== oldest.last_idx)
                        report($sformatf("last_index %0d, expected %0d",
                                         last_index, oldest.last_idx));
                end
            end
        end
        quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned ph;
        int unsigned kind;
        int unsigned len;
        int unsigned budget;
        int unsigned emax;
        longint unsigned tgt;
        bit plantable;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_goal) begin
                settle();
                write_goal(directed_rows[i].goal);
            end
            send_beat(directed_rows[i].value, directed_rows[i].fin, directed_rows[i].typed,
                      directed_rows[i].has, directed_rows[i].ans);
        end

        // Random phases, one target each; the last few run without idling
        for (ph = 0; ph < PHASES; ph++) begin
            kind = (ph < 7) ? ph : $urandom_range(0, 6);
            plantable = 1'b1;
            case (kind)
                0: begin tgt = 0; emax = 3; end
                1: begin tgt = $urandom_range(1, 64); emax = 32'(tgt + tgt / 2 + 1); end
                2: begin
                    tgt = $urandom_range(65, 200000);
                    emax = (tgt > 65535) ? 65535 : 32'(tgt);
                end
                3: begin tgt = 65535; emax = 65535; end
                4: begin tgt = $urandom_range(200001, 65535 * 30); emax = 65535; end
                5: begin tgt = 31'h7FFF_FFFF; emax = 65535; plantable = 1'b0; end
                default: begin
                    tgt = $urandom & 32'h7FFF_FFFF;
                    emax = 65535;
                    plantable = (tgt <= 65535 * 30);
                end
            endcase
            settle();
            tx_idle <= (ph < PHASES - 3) && ($urandom_range(0, 3) != 0);
            rx_idle <= (ph < PHASES - 3) && ($urandom_range(0, 3) != 0);
            write_goal(tgt[TARGET_W-1:0]);

            // Overlong array after an early match
            if (ph == 1) begin
                build_array(tgt, emax, $urandom_range(MAX_LEN + 1, MAX_LEN + 6), 1'b1);
                send_array();
            end
            // Overlong array with no match
            if (ph == 5) begin
                build_array(tgt, emax, $urandom_range(MAX_LEN + 1, MAX_LEN + 3), 1'b0);
                send_array();
            end

            budget = 0;
            while (budget < 8) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 48)
                                                  : $urandom_range(1, 12);
                build_array(tgt, emax, len, plantable && $urandom_range(0, 2) != 0);
                budget += array_elems.size();
                send_array();
            end
        end

        settle();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
